// ===== hw/rtl/dec_pkg.sv =====
// ----------------------------------------------------------------------------
// dec_pkg
// Shared types and constants for the diagonal edge convolution block.
// ----------------------------------------------------------------------------
package dec_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CFG_W      = 13;
    localparam int PEND_W     = 11;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;

    localparam logic [WID_W-1:0] MIN_WIDTH   = WID_W'(3);
    localparam logic [WID_W-1:0] WIDTH_LIMIT = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] MIN_HEIGHT  = HGT_W'(3);
    localparam logic [HGT_W-1:0] HGT_LIMIT   = HGT_W'(MAX_HEIGHT);
    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(640);
    localparam logic [HGT_W-1:0] HGT_RESET   = HGT_W'(480);

    localparam logic signed [15:0] FULL_SCALE = 16'sd255;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic PORT_A = 1'b0;
    localparam logic PORT_B = 1'b1;

    typedef struct packed {
        logic emit;
        logic pix;
        logic edge_op;
        logic par;
        logic src_bank;
        logic src_port;
        logic frame_end;
    } s1_ctrl_t;

endpackage

// ===== hw/rtl/diagonal_edge_convolution_3x3.sv =====
// ----------------------------------------------------------------------------
// diagonal_edge_convolution_3x3
// Streaming 3x3 diagonal edge filter over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_write_en/cfg_index/cfg_data set frame_width (0) and frame_height (1);
//   write them only while no request is in flight.
//   Input requests (in_valid/in_ready) carry cmd and one RGB pixel; cmd
//   flush drains one pending pixel of the frame tail.
//   Output requests (out_valid/out_ready) carry the filtered pixel and
//   frame_end on the last pixel of a frame.
//   Each result belongs to the pixel one row plus one pixel back; the first
//   frame_width+1 pixels of a frame give no result, and after the last pixel
//   frame_width+1 flush requests drain the tail.
//   Two register stages: the read stage, then the output register that
//   drives out_valid. Throughput is one request per cycle while the receiver
//   does not stall, set by the line store: two row banks with one write and
//   two read ports each serve the stored neighbours of a pixel in one access.
//   Three channel lanes compute in parallel and merge into the output register.
//   When the receiver stalls, one result waits in the output register and one
//   more in the read stage; in_ready drops only when both are full.
//   Reset restores 640x480, clears counters and empties the pipeline; the
//   line store needs no clearing.
// ----------------------------------------------------------------------------
module diagonal_edge_convolution_3x3
    import dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [CHAN_W-1:0] red_in,
    input  logic [CHAN_W-1:0] green_in,
    input  logic [CHAN_W-1:0] blue_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0] red_out,
    output logic [CHAN_W-1:0] green_out,
    output logic [CHAN_W-1:0] blue_out,
    output logic              frame_end
);

    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    s1_ctrl_t          s1_ctrl_reg;
    s1_ctrl_t          s1_ctrl_next;
    logic [PIX_W-1:0]  s1_cur_reg;
    logic [PIX_W-1:0]  ud0_reg;
    logic [PIX_W-1:0]  ud1_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_end_reg;

    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic [PEND_W-1:0] pc_eff;
    logic              in_acc;
    logic              s1_adv;
    logic              out_load;
    logic              is_pixel;
    logic              p;
    logic              tail_corner;

    logic [COL_W-1:0]  addr_a [2];
    logic [COL_W-1:0]  addr_b [2];
    logic              bank_we [2];
    logic [PIX_W-1:0]  rd_a [2];
    logic [PIX_W-1:0]  rd_b [2];

    logic [PIX_W-1:0]  ur;
    logic [PIX_W-1:0]  ll;
    logic [PIX_W-1:0]  pass;
    logic [PIX_W-1:0]  merged;

    // effective geometry
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < MIN_WIDTH)
        begin
            w_eff = MIN_WIDTH;
        end
        else if (width_reg > WIDTH_LIMIT)
        begin
            w_eff = WIDTH_LIMIT;
        end
        h_eff = height_reg;
        if (height_reg < MIN_HEIGHT)
        begin
            h_eff = MIN_HEIGHT;
        end
        else if (height_reg > HGT_LIMIT)
        begin
            h_eff = HGT_LIMIT;
        end
    end

    always_comb
    begin
        c = col_reg;
        if (WID_W'(col_reg) >= w_eff)
        begin
            c = COL_W'(w_eff - WID_W'(1));
        end
        r = row_reg;
        if (HGT_W'(row_reg) >= h_eff)
        begin
            r = ROW_W'(h_eff - HGT_W'(1));
        end
        pc_eff = pend_reg;
        if (pend_reg > w_eff + WID_W'(1))
        begin
            pc_eff = w_eff + WID_W'(1);
        end
    end

    assign s1_adv   = s1_valid_reg & (~s1_ctrl_reg.emit | ~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | s1_adv;
    assign in_acc   = in_valid & in_ready;
    assign out_load = s1_adv & s1_ctrl_reg.emit;
    assign is_pixel = (cmd == CMD_PIXEL);
    assign p        = r[0];
    assign tail_corner = (pc_eff == w_eff + WID_W'(1));

    // address generation, counters and read-stage control
    always_comb
    begin
        addr_a[0]     = c;
        addr_a[1]     = c;
        addr_b[0]     = c;
        addr_b[1]     = c;
        bank_we[0]    = 1'b0;
        bank_we[1]    = 1'b0;
        col_next      = col_reg;
        row_next      = row_reg;
        pend_next     = pend_reg;
        s1_ctrl_next  = s1_ctrl_reg;
        s1_valid_next = s1_valid_reg & ~s1_adv;

        if (in_acc)
        begin
            if (is_pixel)
            begin
                addr_a[p]  = c;
                addr_b[p]  = (c == '0) ? COL_W'(w_eff - WID_W'(1)) : c - COL_W'(2);
                addr_a[~p] = c - COL_W'(1);
                bank_we[p] = 1'b1;

                s1_valid_next          = 1'b1;
                s1_ctrl_next.pix       = 1'b1;
                s1_ctrl_next.emit      = (r >= ROW_W'(2)) | ((r == ROW_W'(1)) & (c != '0));
                s1_ctrl_next.edge_op   = 1'b0;
                s1_ctrl_next.par       = p;
                s1_ctrl_next.frame_end = 1'b0;
                if (c == '0)
                begin
                    s1_ctrl_next.src_bank = p;
                    s1_ctrl_next.src_port = PORT_B;
                end
                else
                begin
                    s1_ctrl_next.edge_op  = (r >= ROW_W'(2)) & (c >= COL_W'(2));
                    s1_ctrl_next.src_bank = ~p;
                    s1_ctrl_next.src_port = PORT_A;
                end

                pend_next = '0;
                if (WID_W'(c) + WID_W'(1) >= w_eff)
                begin
                    col_next = '0;
                    if (HGT_W'(r) + HGT_W'(1) >= h_eff)
                    begin
                        row_next  = '0;
                        pend_next = w_eff + WID_W'(1);
                    end
                    else
                    begin
                        row_next = r + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = c + COL_W'(1);
                    row_next = r;
                end
            end
            else if (pend_reg != '0)
            begin
                s1_valid_next          = 1'b1;
                s1_ctrl_next.pix       = 1'b0;
                s1_ctrl_next.emit      = 1'b1;
                s1_ctrl_next.edge_op   = 1'b0;
                s1_ctrl_next.par       = p;
                s1_ctrl_next.src_port  = PORT_A;
                s1_ctrl_next.frame_end = (pc_eff == PEND_W'(1));
                if (tail_corner)
                begin
                    s1_ctrl_next.src_bank   = h_eff[0];
                    addr_a[h_eff[0]]        = COL_W'(w_eff - WID_W'(1));
                end
                else
                begin
                    s1_ctrl_next.src_bank   = ~h_eff[0];
                    addr_a[~h_eff[0]]       = COL_W'(w_eff - pc_eff);
                end
                pend_next = pc_eff - PEND_W'(1);
            end
        end
    end

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        dec_row_bank u_bank
        (
            .clk     (clk),
            .we      (bank_we[b]),
            .waddr   (c),
            .wdata   ({red_in, green_in, blue_in}),
            .re      (in_acc),
            .raddr_a (addr_a[b]),
            .raddr_b (addr_b[b]),
            .rdata_a (rd_a[b]),
            .rdata_b (rd_b[b])
        );
    end

    assign ur   = rd_a[s1_ctrl_reg.par];
    assign ll   = rd_b[s1_ctrl_reg.par];
    assign pass = (s1_ctrl_reg.src_port == PORT_B) ? rd_b[s1_ctrl_reg.src_bank]
                                                   : rd_a[s1_ctrl_reg.src_bank];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        dec_lane u_lane
        (
            .edge_op (s1_ctrl_reg.edge_op),
            .ul      (ud1_reg[k*CHAN_W +: CHAN_W]),
            .ur      (ur[k*CHAN_W +: CHAN_W]),
            .ll      (ll[k*CHAN_W +: CHAN_W]),
            .lr      (s1_cur_reg[k*CHAN_W +: CHAN_W]),
            .pass    (pass[k*CHAN_W +: CHAN_W]),
            .result  (merged[k*CHAN_W +: CHAN_W])
        );
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HGT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= s1_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_cur_reg  <= {red_in, green_in, blue_in};
        end
        if (s1_adv & s1_ctrl_reg.pix)
        begin
            ud0_reg <= ur;
            ud1_reg <= ud0_reg;
        end
        if (out_load)
        begin
            out_pix_reg <= merged;
            out_end_reg <= s1_ctrl_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg[2*CHAN_W +: CHAN_W];
    assign green_out = out_pix_reg[CHAN_W +: CHAN_W];
    assign blue_out  = out_pix_reg[0 +: CHAN_W];
    assign frame_end = out_end_reg;

endmodule

// ===== hw/rtl/dec_row_bank.sv =====
// ----------------------------------------------------------------------------
// dec_row_bank
// One row of the line store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dec_row_bank
    import dec_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [COL_W-1:0] waddr,
    input  logic [PIX_W-1:0] wdata,
    input  logic             re,
    input  logic [COL_W-1:0] raddr_a,
    input  logic [COL_W-1:0] raddr_b,
    output logic [PIX_W-1:0] rdata_a,
    output logic [PIX_W-1:0] rdata_b
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ===== hw/rtl/dec_lane.sv =====
// ----------------------------------------------------------------------------
// dec_lane
// One color channel: diagonal edge kernel, gain, clamp and border bypass.
// ----------------------------------------------------------------------------
module dec_lane
    import dec_pkg::*;
(
    input  logic              edge_op,
    input  logic [CHAN_W-1:0] ul,
    input  logic [CHAN_W-1:0] ur,
    input  logic [CHAN_W-1:0] ll,
    input  logic [CHAN_W-1:0] lr,
    input  logic [CHAN_W-1:0] pass,
    output logic [CHAN_W-1:0] result
);

    logic signed [10:0] ul_s;
    logic signed [10:0] ur_s;
    logic signed [10:0] ll_s;
    logic signed [10:0] lr_s;
    logic signed [10:0] sum;
    logic signed [15:0] sum_x;
    logic signed [15:0] level;
    logic [CHAN_W-1:0]  clamped;

    always_comb
    begin
        ul_s  = {3'b000, ul};
        ur_s  = {3'b000, ur};
        ll_s  = {3'b000, ll};
        lr_s  = {3'b000, lr};
        sum   = ul_s - ur_s - ll_s + lr_s;
        sum_x = {{5{sum[10]}}, sum};
        // gain of 20 as 16 + 4
        level = FULL_SCALE - ((sum_x <<< 4) + (sum_x <<< 2));
        if (level < 16'sd0)
        begin
            clamped = '0;
        end
        else if (level > FULL_SCALE)
        begin
            clamped = '1;
        end
        else
        begin
            clamped = level[CHAN_W-1:0];
        end
        result = edge_op ? clamped : pass;
    end

endmodule
